@@ rtl/core/pdas_pkg.sv @@
package pdas_pkg;

  // Decoded job action
  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DISP  = 2'd1,
    OP_PURGE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam int unsigned QUANTUM_RESET = 64;
  localparam int unsigned QUANTUM_W     = 13;
  localparam int unsigned IN_DATA_W     = 40;
  localparam int unsigned OUT_DATA_W    = 64;

  // Classified command handed from front to back
  typedef struct packed {
    op_t         op;
    logic [7:0]  prio;
    logic [5:0]  dom;
    logic [5:0]  client;
    logic [15:0] rows;
  } cmd_t;

  // One job table entry
  typedef struct packed {
    logic [7:0]  prio;
    logic [5:0]  dom;
    logic [5:0]  client;
    logic [15:0] rows;
    logic [15:0] next_row;
    logic [31:0] age;
  } entry_t;

  // Result beat, last field in the low bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [8:0]  queued_count;
    logic        job_done;
    logic [15:0] slice_rows;
    logic [15:0] slice_start;
    logic [5:0]  slice_client;
    logic [7:0]  slot;
    logic        ok;
  } res_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic        busy;
    logic        cnt_ovf;
  } stat_t;

endpackage

@@ rtl/core/pdas_front.sv @@
module pdas_front
  import pdas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_pop
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       push;

  // Classify the incoming beat
  always_comb begin
    dec.op     = op_t'(in_tdata[1:0]);
    dec.prio   = in_tdata[9:2];
    dec.dom    = in_tdata[15:10];
    dec.client = in_tdata[21:16];
    dec.rows   = in_tdata[37:22];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_mem_r[rd_ptr_r];

  // Two-deep command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_mem_r[wr_ptr_r] <= dec;
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

@@ rtl/core/pdas_back.sv @@
module pdas_back
  import pdas_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [QUANTUM_W-1:0]  cfg_wr_data,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output stat_t                 stat
);

  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned IDX_W  = SLOT_W + 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 p_vld_r, p_valid_r;
  logic [SLOT_W-1:0]    p_idx_r;
  entry_t               rd_q_r;
  entry_t               tbl_mem_r [QUEUE_DEPTH];
  logic                 have_r;
  logic [SLOT_W-1:0]    best_idx_r;
  entry_t               best_r;
  logic [31:0]          seq_r;
  logic [CNT_W-1:0]     count_r;
  logic [5:0]           act_dom_r;
  logic [QUANTUM_W-1:0] quantum_r;
  logic                 out_vld_r;
  res_t                 res_r;

  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_wa;
  entry_t               mem_wd;
  logic                 better;
  logic                 cand_aff, best_aff;
  logic                 can_out;
  logic [15:0]          remaining, take;
  logic [QUANTUM_W-1:0] q_eff;
  logic [16:0]          new_start;
  logic                 disp_done;
  res_t                 res_nxt;
  logic                 out_vld_nxt;

  assign can_out    = !out_vld_r || out_tready;
  assign cmd_pop    = (state_r == S_IDLE) && cmd_valid;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;
  assign stat.busy    = (state_r != S_IDLE);
  assign stat.cnt_ovf = (count_r > CNT_W'(QUEUE_DEPTH));

  // Candidate ranking during a dispatch scan
  always_comb begin
    cand_aff = (rd_q_r.dom == act_dom_r);
    best_aff = (best_r.dom == act_dom_r);
    if (!have_r)                         better = 1'b1;
    else if (rd_q_r.prio != best_r.prio) better = rd_q_r.prio > best_r.prio;
    else if (cand_aff != best_aff)       better = cand_aff;
    else                                 better = rd_q_r.age < best_r.age;
  end

  // Slice sizing for the chosen job
  always_comb begin
    remaining = (best_r.rows > best_r.next_row) ? best_r.rows - best_r.next_row : 16'd0;
    q_eff     = (quantum_r == '0) ? QUANTUM_W'(1) : quantum_r;
    take      = (count_r != CNT_W'(1) && remaining > 16'(q_eff)) ? 16'(q_eff) : remaining;
    new_start = 17'(best_r.next_row) + 17'(take);
    disp_done = new_start >= 17'(best_r.rows);
  end

  // Result beat built in the finish step
  always_comb begin
    res_nxt              = '0;
    res_nxt.queued_count = 9'(count_r);
    if (have_r && cmd_r.op == OP_ENQ) begin
      res_nxt.ok           = 1'b1;
      res_nxt.slot         = 8'(best_idx_r);
      res_nxt.queued_count = 9'(count_r + 1'b1);
    end else if (have_r && cmd_r.op == OP_DISP) begin
      res_nxt.ok           = 1'b1;
      res_nxt.slot         = 8'(best_idx_r);
      res_nxt.slice_client = best_r.client;
      res_nxt.slice_start  = best_r.next_row;
      res_nxt.slice_rows   = take;
      res_nxt.job_done     = disp_done;
      if (disp_done) res_nxt.queued_count = 9'(count_r - 1'b1);
    end
  end

  // Result valid: set on finish, held until taken
  assign out_vld_nxt = (state_r == S_FINISH && can_out) || (out_vld_r && !out_tready);

  // Table write in the finish step
  always_comb begin
    mem_we = 1'b0;
    mem_wa = best_idx_r;
    mem_wd = best_r;
    if (state_r == S_FINISH && can_out && have_r) begin
      if (cmd_r.op == OP_ENQ) begin
        mem_we        = 1'b1;
        mem_wd.prio   = cmd_r.prio;
        mem_wd.dom    = cmd_r.dom;
        mem_wd.client = cmd_r.client;
        mem_wd.rows   = cmd_r.rows;
        mem_wd.next_row = '0;
        mem_wd.age    = seq_r;
      end else if (cmd_r.op == OP_DISP) begin
        mem_we          = 1'b1;
        mem_wd.next_row = new_start[15:0];
      end
    end
  end

  // Job table memory
  always_ff @(posedge clk) begin
    if (mem_we) tbl_mem_r[mem_wa] <= mem_wd;
    rd_q_r <= tbl_mem_r[rd_idx_r[SLOT_W-1:0]];
  end

  // Sequencer, table valid bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      p_vld_r   <= 1'b0;
      seq_r     <= '0;
      count_r   <= '0;
      act_dom_r <= '0;
      quantum_r <= QUANTUM_W'(QUANTUM_RESET);
      out_vld_r <= 1'b0;
      have_r    <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      if (cfg_wr_en) quantum_r <= cfg_wr_data;
      out_vld_r <= out_vld_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r    <= cmd;
            rd_idx_r <= '0;
            have_r   <= 1'b0;
            p_vld_r  <= 1'b0;
            state_r  <= (cmd.op == OP_NONE) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read per cycle
          if (rd_idx_r != IDX_W'(QUEUE_DEPTH)) begin
            p_vld_r   <= 1'b1;
            p_idx_r   <= rd_idx_r[SLOT_W-1:0];
            p_valid_r <= valid_r[rd_idx_r[SLOT_W-1:0]];
            rd_idx_r  <= rd_idx_r + 1'b1;
          end else begin
            p_vld_r <= 1'b0;
            state_r <= S_FINISH;
          end
          // evaluate the slot read last cycle
          if (p_vld_r) begin
            case (cmd_r.op)
              OP_ENQ: begin
                if (!p_valid_r && !have_r) begin
                  have_r     <= 1'b1;
                  best_idx_r <= p_idx_r;
                end
              end
              OP_DISP: begin
                if (p_valid_r && better) begin
                  have_r     <= 1'b1;
                  best_idx_r <= p_idx_r;
                  best_r     <= rd_q_r;
                end
              end
              OP_PURGE: begin
                if (p_valid_r && rd_q_r.client == cmd_r.client) begin
                  valid_r[p_idx_r] <= 1'b0;
                  count_r          <= count_r - 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_FINISH: begin
          if (can_out) begin
            res_r   <= res_nxt;
            state_r <= S_IDLE;
            if (have_r && cmd_r.op == OP_ENQ) begin
              valid_r[best_idx_r] <= 1'b1;
              seq_r               <= seq_r + 1'b1;
              count_r             <= count_r + 1'b1;
            end else if (have_r && cmd_r.op == OP_DISP) begin
              act_dom_r <= best_r.dom;
              if (disp_done) begin
                valid_r[best_idx_r] <= 1'b0;
                count_r             <= count_r - 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/priority_domain_affinity_scheduler_top.sv @@
// Channel  | Direction | Ports            | Beat contents
// in_      | slave     | tvalid/tready    | tdata: action, priority_req, job_domain,
//          |           | tdata[39:0]      |        client, total_rows (low bit up)
// out_     | master    | tvalid/tready    | tdata: ok, slot, slice_client, slice_start,
//          |           | tdata[63:0]      |        slice_rows, job_done, queued_count
// cfg_     | write     | wr_en, wr_data   | quantum_rows
//
// Each beat scans the whole job table in the back end (one table slot read per
// cycle through the single read port of the job table); action code three skips the scan.
// A two-beat command queue keeps accepting input while the back end works.
// Synchronous active-low reset empties the table at once; no clearing pass.
// A stalled result holds the back end in its finish step only.
module priority_domain_affinity_scheduler_top
  import pdas_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [QUANTUM_W-1:0]  cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // action, priority_req, job_domain, client, total_rows
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // ok, slot, slice_client, slice_start,
                                            // slice_rows, job_done, queued_count
);

  logic  cmd_valid, cmd_pop;
  cmd_t  cmd;
  stat_t stat;
  res_t  res;

  pdas_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cmd_valid, .cmd, .cmd_pop
  );

  pdas_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .cmd_valid, .cmd, .cmd_pop,
    .out_tvalid, .out_tready, .out_tdata, .stat
  );

  assign res = out_tdata;

  // job count never exceeds the table size
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) !stat.cnt_ovf)
    else $error("job count overflow");

  // a finished job always comes with an issued slice
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.job_done |-> res.ok)
    else $error("job_done without ok");

  // a new result only appears after the back end worked on a command
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(stat.busy))
    else $error("result without work");

endmodule
